@@ src/gbfr_pkg.sv @@
// Shared types and constants for the binary frame resync parser.
// No dependencies; used by gbfr_front, gbfr_back and the top level.
package gbfr_pkg;

    // Frame buffer geometry
    localparam int MAX_FRAME = 1024;
    localparam int ADDR_W    = $clog2(MAX_FRAME);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int HDR_LEN   = 6;
    localparam int CK_LEN    = 2;

    // Configuration register indexes
    localparam logic REG_SYNC_FIRST  = 1'b0;
    localparam logic REG_SYNC_SECOND = 1'b1;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_READ    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    // Request handed from the front to the back
    typedef struct packed {
        t_op         op;
        logic [7:0]  data;
        logic [9:0]  idx;
    } t_req;

    // Result word
    typedef struct packed {
        logic        accepted;
        logic        ready;
        logic [10:0] held;
        logic [10:0] dropped;
        logic [9:0]  plen;
        logic [7:0]  rdata;
    } t_result;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_B0,
        S_B1,
        S_L0,
        S_L1,
        S_L2,
        S_SUM,
        S_DROP,
        S_RD,
        S_FIN
    } t_state;

endpackage

@@ src/gbfr_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gbfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/gbfr_front.sv @@
// Front end: two-entry request queue that accepts and classifies requests.
// Depends on gbfr_pkg.
module gbfr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [1:0]    i_opcode,
    input  logic [7:0]    i_data_byte,
    input  logic [9:0]    i_read_index,
    output logic          o_req_valid,
    input  logic          i_req_take,
    output gbfr_pkg::t_req o_req
);
    import gbfr_pkg::*;

    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_full      = (r_cnt == 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign wr = i_push && !o_full;
    assign rd = i_req_take && o_req_valid;

    // Classified request storage
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= '{op: t_op'(i_opcode), data: i_data_byte, idx: i_read_index};
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

@@ src/gbfr_back.sv @@
// Back end: frame buffer, resync/checksum sequencer and result register.
// Depends on gbfr_pkg and gbfr_ram.
module gbfr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_sync0,
    input  logic [7:0]         i_sync1,
    input  logic               i_req_valid,
    output logic               o_req_take,
    input  gbfr_pkg::t_req     i_req,
    output logic               o_res_valid,
    input  logic               i_res_pop,
    output gbfr_pkg::t_result  o_res
);
    import gbfr_pkg::*;

    t_state              r_state, n_state;
    t_req                r_req, n_req;
    logic [ADDR_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_drop, n_drop;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [9:0]          r_len, n_len;
    logic [7:0]          r_lo, n_lo;
    logic [7:0]          r_a, n_a, r_b, n_b, r_rd, n_rd;
    logic                r_ok_a, n_ok_a, r_ready, n_ready, r_acc, n_acc;
    t_result             r_out, n_out;
    logic                r_out_v, n_out_v;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [7:0]          ram_rdata;

    logic                take, can_push, miss_neg;
    logic [16:0]         len17;
    logic                len_bad, tot_eq;
    logic [CNT_W-1:0]    len_tot, cnt_m2, cnt_m1, fin_count, fin_drop;
    logic [7:0]          sum_a;

    // The byte is written in the cycle the push request is taken, if it is accepted
    gbfr_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_req.data),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared compares
    assign take     = (r_state == S_IDLE) && i_req_valid && !r_out_v;
    assign len_tot  = CNT_W'(r_len) + CNT_W'(HDR_LEN + CK_LEN);
    assign can_push = ((r_count < CNT_W'(HDR_LEN)) || (len_tot > r_count))
                      && (r_count < CNT_W'(MAX_FRAME));
    assign miss_neg = (r_count >= CNT_W'(HDR_LEN)) && (len_tot < r_count);
    assign len17    = {1'b0, ram_rdata, r_lo} + 17'(HDR_LEN + CK_LEN);
    assign len_bad  = len17 > 17'(MAX_FRAME);
    assign tot_eq   = len17 == 17'(r_count);
    assign cnt_m2   = r_count - CNT_W'(CK_LEN);
    assign cnt_m1   = r_count - CNT_W'(1);
    assign sum_a    = r_a + ram_rdata;
    assign fin_count = miss_neg ? '0 : r_count;
    assign fin_drop  = miss_neg ? (r_drop + r_count) : r_drop;
    assign o_req_take  = take;
    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (i_req.op)
                        OP_PUSH: n_state = S_B0;
                        OP_READ: n_state = S_RD;
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_B0:   n_state = (r_count == '0) ? S_FIN : S_B1;
            S_B1: begin
                if (ram_rdata != i_sync0)         n_state = S_DROP;
                else if (r_count < CNT_W'(2))     n_state = S_FIN;
                else                              n_state = S_L0;
            end
            S_L0: begin
                if (ram_rdata != i_sync1)              n_state = S_DROP;
                else if (r_count < CNT_W'(HDR_LEN))    n_state = S_FIN;
                else                                   n_state = S_L1;
            end
            S_L1:   n_state = S_L2;
            S_L2: begin
                if (len_bad)      n_state = S_DROP;
                else if (!tot_eq) n_state = S_FIN;
                else              n_state = S_SUM;
            end
            S_SUM: begin
                if (r_idx == cnt_m1) begin
                    n_state = (r_ok_a && (r_b == ram_rdata)) ? S_FIN : S_DROP;
                end
            end
            S_DROP: n_state = S_B0;
            S_RD:   n_state = S_FIN;
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_req   = r_req;
        n_head  = r_head;
        n_count = r_count;
        n_drop  = r_drop;
        n_idx   = r_idx;
        n_len   = r_len;
        n_lo    = r_lo;
        n_a     = r_a;
        n_b     = r_b;
        n_rd    = r_rd;
        n_ok_a  = r_ok_a;
        n_ready = r_ready;
        n_acc   = r_acc;
        n_out   = r_out;
        n_out_v = r_out_v;
        ram_we    = 1'b0;
        ram_waddr = r_head + r_count[ADDR_W-1:0];
        ram_raddr = r_head;
        if (i_res_pop && r_out_v) n_out_v = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_req  = i_req;
                    n_drop = '0;
                    n_acc  = 1'b0;
                    n_rd   = '0;
                    case (i_req.op)
                        OP_PUSH: begin
                            n_ready = 1'b0;
                            if (can_push) begin
                                ram_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                n_acc   = 1'b1;
                            end
                        end
                        OP_READ: ram_raddr = r_head + i_req.idx;
                        OP_RELEASE: begin
                            n_count = '0;
                            n_ready = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_B0: ram_raddr = r_head;
            S_B1: ram_raddr = r_head + ADDR_W'(1);
            S_L0: ram_raddr = r_head + ADDR_W'(4);
            S_L1: begin
                n_lo      = ram_rdata;
                ram_raddr = r_head + ADDR_W'(5);
            end
            S_L2: begin
                n_len     = {ram_rdata[1:0], r_lo};
                n_a       = '0;
                n_b       = '0;
                n_idx     = CNT_W'(2);
                ram_raddr = r_head + ADDR_W'(2);
            end
            // Fletcher sums over bytes 2.., then check the two sum bytes
            S_SUM: begin
                ram_raddr = r_head + r_idx[ADDR_W-1:0] + ADDR_W'(1);
                n_idx     = r_idx + CNT_W'(1);
                if (r_idx < cnt_m2) begin
                    n_a = sum_a;
                    n_b = r_b + sum_a;
                end else if (r_idx == cnt_m2) begin
                    n_ok_a = (r_a == ram_rdata);
                end else if (r_ok_a && (r_b == ram_rdata)) begin
                    n_ready = 1'b1;
                end
            end
            // Drop the oldest byte
            S_DROP: begin
                n_head  = r_head + ADDR_W'(1);
                n_count = cnt_m1;
                n_drop  = r_drop + CNT_W'(1);
            end
            S_RD: begin
                if (CNT_W'(r_req.idx) < r_count) n_rd = ram_rdata;
            end
            // Clear on over-long hold, then post the result
            S_FIN: begin
                n_count = fin_count;
                n_out_v = 1'b1;
                n_out.accepted = r_acc;
                n_out.ready    = r_ready;
                n_out.held     = fin_count;
                n_out.dropped  = fin_drop;
                n_out.plen     = (fin_count >= CNT_W'(HDR_LEN)) ? r_len : '0;
                n_out.rdata    = r_rd;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_ready <= 1'b0;
            r_out_v <= 1'b0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_ready <= n_ready;
            r_out_v <= n_out_v;
            r_len   <= n_len;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_drop <= n_drop;
        r_idx  <= n_idx;
        r_lo   <= n_lo;
        r_a    <= n_a;
        r_b    <= n_b;
        r_rd   <= n_rd;
        r_ok_a <= n_ok_a;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end
endmodule

@@ src/gnss_binary_frame_resync_parser.sv @@
// Top level of the binary frame resync parser with Fletcher-8 check.
// Depends on gbfr_pkg, gbfr_front, gbfr_back (and gbfr_ram below it).
//
//  channel   handshake            payload
//  -------   ------------------   ------------------------------------------
//  request   push / full          i_opcode, i_data_byte, i_read_index
//  result    empty / pop          o_byte_accepted .. o_read_data
//  config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// A push runs the header reads for each window checked and, for a
// full-length window, a checksum scan over each held byte past the sync
// bytes through the single RAM read port; each dropped byte adds a new
// check.
// Reset is synchronous and empties the buffer; the front queue holds two
// requests, so up to two requests are queued while a result waits for pop.
module gnss_binary_frame_resync_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    input  logic [9:0]  i_read_index,
    output logic        empty,
    input  logic        pop,
    output logic        o_byte_accepted,
    output logic        o_frame_ready,
    output logic [10:0] o_held_bytes,
    output logic [10:0] o_dropped_bytes,
    output logic [9:0]  o_payload_length,
    output logic [7:0]  o_read_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import gbfr_pkg::*;

    logic [7:0] r_sync0, r_sync1;
    logic       req_valid, req_take, res_valid;
    t_req       req;
    t_result    res;

    // Sync byte registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync0 <= 8'd181;
            r_sync1 <= 8'd98;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SYNC_FIRST:  r_sync0 <= i_cfg_data;
                REG_SYNC_SECOND: r_sync1 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gbfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_opcode     (i_opcode),
        .i_data_byte  (i_data_byte),
        .i_read_index (i_read_index),
        .o_req_valid  (req_valid),
        .i_req_take   (req_take),
        .o_req        (req)
    );

    gbfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sync0     (r_sync0),
        .i_sync1     (r_sync1),
        .i_req_valid (req_valid),
        .o_req_take  (req_take),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_pop   (pop),
        .o_res       (res)
    );

    assign empty            = !res_valid;
    assign o_byte_accepted  = res.accepted;
    assign o_frame_ready    = res.ready;
    assign o_held_bytes     = res.held;
    assign o_dropped_bytes  = res.dropped;
    assign o_payload_length = res.plen;
    assign o_read_data      = res.rdata;
endmodule
